FILE: rtl/frml_pkg.sv
package frml_pkg;

  // ring depth and derived widths
  localparam int unsigned WINDOW_SAMPLES = 10;
  localparam int unsigned RING_AW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = TIME_W + $clog2(WINDOW_SAMPLES);

  // fps in q.8: 1000 ms * 256
  localparam longint unsigned FPS_SCALE = 256000;
  localparam int unsigned FPS_W = 22;
  localparam logic [FPS_W-1:0] FPS_Q8_MAX     = 22'd4194303;
  localparam logic [FPS_W-1:0] FPS_Q8_DEFAULT = 22'd15360;

  localparam int unsigned DELAY_W = 10;
  localparam int unsigned FPS_CFG_W = 16;
  localparam logic [FPS_CFG_W-1:0] MAX_FPS_RESET = 16'd60000;
  localparam int unsigned MS_PER_SEC = 1000;

  // shared divider widths
  localparam int unsigned DIV_NW = $clog2(FPS_SCALE * WINDOW_SAMPLES + 1);
  localparam int unsigned DIV_DW = SUM_W;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/frml_div.sv
module frml_div
  import frml_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_NW-1:0] dvd_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] dsr_q;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, dvd_q[DIV_NW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DIV_DW'(trial - {1'b0, dsr_q}) : trial[DIV_DW-1:0];
      dvd_q <= {dvd_q[DIV_NW-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

FILE: rtl/frml_ring.sv
module frml_ring
  import frml_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [TIME_W-1:0]  wr_data_i,
  input  logic [RING_AW-1:0] rd_idx_i,
  output logic [TIME_W-1:0]  rd_data_o,
  output logic [FILL_W-1:0]  fill_o
);

  logic [TIME_W-1:0]  ring_q [WINDOW_SAMPLES];
  logic [TIME_W-1:0]  rd_data_q;
  logic [RING_AW-1:0] slot_q;
  logic [FILL_W-1:0]  fill_q;

  // entries past the fill count are never read, so no clear is needed
  // read data is registered and follows the index in the next cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_q[slot_q] <= wr_data_i;
    end
    rd_data_q <= ring_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else if (wr_en_i) begin
      slot_q <= (slot_q == RING_AW'(WINDOW_SAMPLES - 1)) ? '0 : slot_q + RING_AW'(1);
      if (fill_q != FILL_W'(WINDOW_SAMPLES)) begin
        fill_q <= fill_q + FILL_W'(1);
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign fill_o    = fill_q;

endmodule

FILE: rtl/frame_rate_meter_limiter.sv
// channel   | dir | handshake                       | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready   | start_ms, end_ms
// m_axis    | out | m_axis_tvalid / m_axis_tready   | fps_q8, interval_ms, delay_ms
// apb       | in  | psel & penable, pready tied high | max_fps at byte address 0
//
// the time a word takes is set by the serial sum over the filled entries of the
// 10 entry ring and by two passes of the shared one-bit-per-cycle divider; a zero sum
// skips the fps division
// s_axis_tready is high only while the sequencer is idle
// the result sits in an output register, so the next word is taken while it waits
// reset clears the ring pointers, the previous end time and max_fps to 60000
module frame_rate_meter_limiter
  import frml_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] start_ms, [63:32] end_ms
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [21:0] fps_q8, [53:22] interval_ms, [63:54] delay_ms
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ADDR_MAX_FPS = 1'b0;

  typedef enum logic [2:0] {
    IDLE,
    SUM,
    SUM_END,
    FPS_ST,
    FPS_WT,
    BUD_ST,
    BUD_WT,
    OUT_ST
  } state_e;

  state_e state_q;

  // configuration register
  logic [FPS_CFG_W-1:0] max_fps_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_MAX_FPS);
  assign prdata = (paddr[2] == ADDR_MAX_FPS) ? 32'(max_fps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fps_q <= MAX_FPS_RESET;
    end else if (cfg_wr) begin
      max_fps_q <= pwdata[FPS_CFG_W-1:0];
    end
  end

  // input fields
  logic [TIME_W-1:0] in_start;
  logic [TIME_W-1:0] in_end;
  logic              in_acc;

  assign in_start = s_axis_tdata[31:0];
  assign in_end   = s_axis_tdata[63:32];
  assign s_axis_tready = (state_q == IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // frame state
  logic [TIME_W-1:0]  last_end_q;
  logic               seen_first_q;
  logic [TIME_W-1:0]  interval;
  logic [TIME_W-1:0]  interval_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [SUM_W-1:0]   sum_q;
  logic [RING_AW-1:0] idx_q;
  logic [FPS_W-1:0]   fps_q;
  logic [DELAY_W-1:0] budget_q;

  // first frame has no previous end time
  assign interval = seen_first_q ? (in_end - last_end_q) : '0;

  // ring of intervals
  logic [TIME_W-1:0] ring_rd;
  logic [FILL_W-1:0] fill;

  frml_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_data_i (interval),
    .rd_idx_i  (idx_q),
    .rd_data_o (ring_rd),
    .fill_o    (fill)
  );

  // shared divider: fps first, then the per-frame budget
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic [FPS_CFG_W-1:0] fps_div;

  // a zero ceiling counts as one
  assign fps_div = (max_fps_q == '0) ? FPS_CFG_W'(1) : max_fps_q;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_NW'(64'(FPS_SCALE) * 64'(fill));
    div_req.divisor  = sum_q;
    case (state_q)
      FPS_ST: begin
        div_req.start = (sum_q != '0);
      end
      BUD_ST: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(MS_PER_SEC);
        div_req.divisor  = DIV_DW'(fps_div);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  frml_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // delay = budget minus frame time, floored at zero
  logic [DELAY_W-1:0] delay;
  assign delay = (TIME_W'(budget_q) > elapsed_q) ? (budget_q - DELAY_W'(elapsed_q)) : '0;

  // output register
  logic        out_free;
  logic        m_valid_q;
  logic [63:0] m_data_q;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      last_end_q   <= '0;
      seen_first_q <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      interval_q   <= '0;
      elapsed_q    <= '0;
      sum_q        <= '0;
      idx_q        <= '0;
      fps_q        <= '0;
      budget_q     <= '0;
    end else begin
      // load a new result or drop the one just taken
      if ((state_q == OUT_ST) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_acc) begin
            last_end_q   <= in_end;
            seen_first_q <= 1'b1;
            interval_q   <= interval;
            elapsed_q    <= in_end - in_start;
            sum_q        <= '0;
            idx_q        <= '0;
            state_q      <= SUM;
          end
        end
        // walk the filled entries, one per cycle; read data is registered behind the index
        SUM: begin
          if (idx_q != '0) begin
            sum_q <= sum_q + SUM_W'(ring_rd);
          end
          if (FILL_W'(idx_q) == fill - FILL_W'(1)) begin
            state_q <= SUM_END;
          end else begin
            idx_q <= idx_q + RING_AW'(1);
          end
        end
        // last entry read comes in
        SUM_END: begin
          sum_q   <= sum_q + SUM_W'(ring_rd);
          state_q <= FPS_ST;
        end
        FPS_ST: begin
          if (sum_q == '0) begin
            fps_q   <= FPS_Q8_DEFAULT;
            state_q <= BUD_ST;
          end else begin
            state_q <= FPS_WT;
          end
        end
        FPS_WT: begin
          if (div_rsp.done) begin
            fps_q   <= (64'(div_rsp.quotient) > 64'(FPS_Q8_MAX)) ?
                       FPS_Q8_MAX : FPS_W'(div_rsp.quotient);
            state_q <= BUD_ST;
          end
        end
        BUD_ST: begin
          state_q <= BUD_WT;
        end
        BUD_WT: begin
          if (div_rsp.done) begin
            budget_q <= DELAY_W'(div_rsp.quotient);
            state_q  <= OUT_ST;
          end
        end
        OUT_ST: begin
          if (out_free) begin
            m_data_q  <= {delay, interval_q, fps_q};
            state_q   <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/frml_chk.sv
module frml_chk
  import frml_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // one word in flight: no new word right after one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  // a fresh result only appears while the sequencer is busy
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result without work");

  // delay never exceeds one second
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[63:54] <= 10'(MS_PER_SEC)))
    else $error("delay out of range");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind frame_rate_meter_limiter frml_chk u_frml_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
